/* sv/cpd_pkg.sv */
package cpd_pkg;

	// Parser phases of the frame hunter
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_ADDR   = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_LEN_HI = 3'd3,
		PH_TYPE   = 3'd4,
		PH_DATA   = 3'd5,
		PH_CRC_LO = 3'd6,
		PH_CRC_HI = 3'd7
	} phase_t;

	// Input item kinds
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_RESYNC = 1'b1;

	// Result item kinds
	localparam logic RES_PAYLOAD = 1'b0;
	localparam logic RES_VERDICT = 1'b1;

	// Verdict codes
	localparam logic [1:0] VERDICT_OK   = 2'd0;
	localparam logic [1:0] VERDICT_CRC  = 2'd1;
	localparam logic [1:0] VERDICT_ADDR = 2'd2;

	localparam logic [7:0]  SYNC_BYTE  = 8'h42;
	localparam logic [7:0]  ADDR_ZERO  = 8'h00;
	localparam logic [7:0]  ADDR_BCAST = 8'hFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// Configuration space
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_WAIT_TYPE = 1'b0;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic [7:0]  frame_addr;
		logic [7:0]  frame_type;
		logic [15:0] frame_len;
		logic [1:0]  verdict;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
		logic        type_matched;
	} result_t;

	// One byte of CRC-16, MSB first, no reflection
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		logic [7:0]  d;
		c = crc;
		d = data;
		for (int i = 0; i < 8; i++) begin
			if (c[15] ^ d[7]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
			d = {d[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* sv/crc16_packet_deframer.sv */
// An accepted item's result passes the input register, then the result register.
// Throughput: one item per cycle, set by the single byte-wide CRC and parser step
// between the input register and the result register.
// A held result stalls input only when the next item also yields a result.
// Reset (arst_n low, asynchronous): parser idle, header, count, CRC and wait_type
// cleared, no item held in either register.
module crc16_packet_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpd_pkg::PADDR_W-1:0]   paddr,
	input  logic [cpd_pkg::PDATA_W-1:0]   pwdata,
	output logic [cpd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [7:0]                    rx_byte,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          result_kind,
	output logic [7:0]                    payload_byte,
	output logic [15:0]                   byte_index,
	output logic [7:0]                    frame_addr,
	output logic [7:0]                    frame_type,
	output logic [15:0]                   frame_len,
	output logic [1:0]                    verdict,
	output logic [15:0]                   computed_crc,
	output logic [15:0]                   received_crc,
	output logic                          type_matched
);

	logic [7:0]        wait_type;
	logic              res_free;
	logic              res_load;
	cpd_pkg::result_t  res_next;
	cpd_pkg::result_t  res_held;

	// Register file: holds the type that raises the match flag on an accepted frame
	cpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.wait_type (wait_type)
	);

	// Parser: register the incoming item, then advance phase, header fields,
	// payload count and running CRC in one step; build the result alongside
	cpd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.wait_type (wait_type),
		.res_free  (res_free),
		.res_load  (res_load),
		.res       (res_next)
	);

	// Result register: hold a finished item until the consumer takes it,
	// while the parser keeps taking bytes that produce nothing
	cpd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res_in    (res_next),
		.free      (res_free),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_out   (res_held)
	);

	// Unpack the held result onto the output fields
	assign result_kind  = res_held.result_kind;
	assign payload_byte = res_held.payload_byte;
	assign byte_index   = res_held.byte_index;
	assign frame_addr   = res_held.frame_addr;
	assign frame_type   = res_held.frame_type;
	assign frame_len    = res_held.frame_len;
	assign verdict      = res_held.verdict;
	assign computed_crc = res_held.computed_crc;
	assign received_crc = res_held.received_crc;
	assign type_matched = res_held.type_matched;

endmodule

/* sv/cpd_cfg.sv */
module cpd_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cpd_pkg::PADDR_W-1:0]        paddr,
	input  logic [cpd_pkg::PDATA_W-1:0]        pwdata,
	output logic [cpd_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	output logic [7:0]                         wait_type
);

	logic [7:0] wait_type_q;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == cpd_pkg::REG_WAIT_TYPE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_type_q <= 8'h00;
		end else if (psel && penable && pwrite && reg_hit) begin
			wait_type_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = {{(cpd_pkg::PDATA_W - 8){1'b0}}, wait_type_q};
		end
	end

	assign wait_type = wait_type_q;

endmodule

/* sv/cpd_parse.sv */
module cpd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        wait_type,
	input  logic              res_free,
	output logic              res_load,
	output cpd_pkg::result_t  res
);

	logic                  valid_s1;
	logic                  kind_s1;
	logic [7:0]            byte_s1;

	cpd_pkg::phase_t       phase_q, phase_d;
	logic [7:0]            addr_q, addr_d;
	logic [15:0]           len_q, len_d;
	logic [7:0]            type_q, type_d;
	logic [15:0]           count_q, count_d;
	logic [15:0]           crc_q, crc_d;
	logic [15:0]           capt_q, capt_d;

	logic                  produce;
	logic                  adv;
	logic [15:0]           crc_upd;
	logic [15:0]           count_inc;
	logic [15:0]           rx_crc;
	logic [1:0]            verdict;

	// A result needs the output slot; items without one always move on
	assign produce  = valid_s1 && (kind_s1 == cpd_pkg::KIND_BYTE) &&
		(phase_q == cpd_pkg::PH_DATA || phase_q == cpd_pkg::PH_CRC_HI);
	assign adv      = valid_s1 && (!produce || res_free);
	assign in_ready = !valid_s1 || adv;
	assign res_load = adv && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cpd_pkg::PH_IDLE;
			addr_q  <= 8'h00;
			len_q   <= 16'h0000;
			type_q  <= 8'h00;
			count_q <= 16'h0000;
			crc_q   <= 16'h0000;
			capt_q  <= 16'h0000;
		end else if (adv) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			len_q   <= len_d;
			type_q  <= type_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			capt_q  <= capt_d;
		end
	end

	assign crc_upd   = cpd_pkg::crc_byte(crc_q, byte_s1);
	assign count_inc = count_q + 16'd1;
	assign rx_crc    = {byte_s1, capt_q[7:0]};

	always_comb begin
		if (rx_crc != crc_q) begin
			verdict = cpd_pkg::VERDICT_CRC;
		end else if (addr_q != cpd_pkg::ADDR_ZERO && addr_q != cpd_pkg::ADDR_BCAST) begin
			verdict = cpd_pkg::VERDICT_ADDR;
		end else begin
			verdict = cpd_pkg::VERDICT_OK;
		end
	end

	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		len_d   = len_q;
		type_d  = type_q;
		count_d = count_q;
		crc_d   = crc_q;
		capt_d  = capt_q;

		res              = '0;
		res.frame_addr   = addr_q;
		res.frame_type   = type_q;
		res.frame_len    = len_q;

		if (kind_s1 == cpd_pkg::KIND_RESYNC) begin
			phase_d = cpd_pkg::PH_IDLE;
		end else begin
			case (phase_q)
				cpd_pkg::PH_IDLE: begin
					if (byte_s1 == cpd_pkg::SYNC_BYTE) begin
						crc_d   = cpd_pkg::crc_byte(16'h0000, byte_s1);
						phase_d = cpd_pkg::PH_ADDR;
					end
				end
				cpd_pkg::PH_ADDR: begin
					addr_d  = byte_s1;
					crc_d   = crc_upd;
					phase_d = cpd_pkg::PH_LEN_LO;
				end
				cpd_pkg::PH_LEN_LO: begin
					len_d   = {8'h00, byte_s1};
					crc_d   = crc_upd;
					phase_d = cpd_pkg::PH_LEN_HI;
				end
				cpd_pkg::PH_LEN_HI: begin
					len_d   = {byte_s1, len_q[7:0]};
					crc_d   = crc_upd;
					phase_d = cpd_pkg::PH_TYPE;
				end
				cpd_pkg::PH_TYPE: begin
					type_d  = byte_s1;
					crc_d   = crc_upd;
					count_d = 16'h0000;
					phase_d = (len_q != 16'h0000) ? cpd_pkg::PH_DATA : cpd_pkg::PH_CRC_LO;
				end
				cpd_pkg::PH_DATA: begin
					res.result_kind  = cpd_pkg::RES_PAYLOAD;
					res.payload_byte = byte_s1;
					res.byte_index   = count_q;
					crc_d   = crc_upd;
					count_d = count_inc;
					if (count_inc >= len_q) begin
						phase_d = cpd_pkg::PH_CRC_LO;
					end
				end
				cpd_pkg::PH_CRC_LO: begin
					capt_d  = {8'h00, byte_s1};
					phase_d = cpd_pkg::PH_CRC_HI;
				end
				cpd_pkg::PH_CRC_HI: begin
					capt_d  = rx_crc;
					phase_d = cpd_pkg::PH_IDLE;
					res.result_kind  = cpd_pkg::RES_VERDICT;
					res.verdict      = verdict;
					res.computed_crc = crc_q;
					res.received_crc = rx_crc;
					res.type_matched = (verdict == cpd_pkg::VERDICT_OK) && (type_q == wait_type);
				end
				default: begin
					phase_d = cpd_pkg::PH_IDLE;
				end
			endcase
		end
	end

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cpd_pkg::PH_DATA) |-> (len_q != 16'h0000))
		else $error("payload phase entered with zero length");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cpd_pkg::PH_DATA) |-> (count_q < len_q))
		else $error("payload count ran past declared length");

	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == cpd_pkg::KIND_RESYNC) |=> (phase_q == cpd_pkg::PH_IDLE))
		else $error("resync did not return parser to idle");

endmodule

/* sv/cpd_out.sv */
module cpd_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cpd_pkg::result_t  res_in,
	output logic              free,
	input  logic              out_ready,
	output logic              out_valid,
	output cpd_pkg::result_t  res_out
);

	logic             valid_q;
	cpd_pkg::result_t res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule
